### hdl/assert_macros.svh
// assertion macros shared by the frame builder rtl
// each macro expects clk and rst_n in scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CRCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder assertion failed");

// next-cycle implication
`define CRCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder assertion failed");

`endif

### hdl/crcf_pkg.sv
// shared types, constants and the crc byte update for the frame builder
// no dependencies
`timescale 1ns / 1ps

package crcf_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h5A;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] MAX_PAYLOAD = 16'd65532;
    localparam logic [15:0] HDR_EXTRA   = 16'd3;
    localparam logic [7:0]  EV_UNKNOWN  = 8'hFF;
    localparam logic [7:0]  EV_TIMING   = 8'd1;
    localparam logic [7:0]  EV_AUTH     = 8'd2;
    localparam logic [7:0]  EV_HEARTBT  = 8'd3;
    localparam logic [7:0]  VERSION_RST = 8'd1;

    // one queued payload byte with everything the back end needs for it
    typedef struct packed {
        logic [15:0] length_field;
        logic [7:0]  event_code;
        logic [7:0]  frame_number;
        logic        last;
        logic        first;
        logic [7:0]  payload;
    } crcf_cmd_t;

    typedef enum logic [3:0] {
        PH_NEW,
        PH_SOF,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_FNUM,
        PH_EVENT,
        PH_VER,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } crcf_phase_t;

    typedef struct packed {
        logic full;
        logic empty;
    } crcf_q_status_t;

    typedef struct packed {
        crcf_phase_t phase;
        logic        pop;
    } crcf_back_status_t;

    // crc-16/modbus over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### hdl/crcf_front.sv
// input side: tracks frame position and classifies each payload byte
// depends on crcf_pkg
`timescale 1ns / 1ps

module crcf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,
    input  crcf_pkg::crcf_q_status_t q_status,
    output logic                 push,
    output crcf_pkg::crcf_cmd_t  push_cmd
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  payload_byte, frame_number, event_code, event_mapped;
    logic [15:0] payload_length, len_sat, eff_total, pos_inc;
    logic        first, last;

    assign payload_byte   = s_tdata[7:0];
    assign payload_length = s_tdata[23:8];
    assign frame_number   = s_tdata[31:24];
    assign event_code     = s_tdata[39:32];

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        if (payload_length == 16'd0)
            len_sat = 16'd1;
        else if (payload_length > crcf_pkg::MAX_PAYLOAD)
            len_sat = crcf_pkg::MAX_PAYLOAD;
        else
            len_sat = payload_length;

        if (event_code == crcf_pkg::EV_TIMING || event_code == crcf_pkg::EV_AUTH
            || event_code == crcf_pkg::EV_HEARTBT)
            event_mapped = event_code;
        else
            event_mapped = crcf_pkg::EV_UNKNOWN;

        first     = (pos_reg == 16'd0);
        eff_total = first ? len_sat : total_reg;
        pos_inc   = pos_reg + 16'd1;
        last      = (pos_inc >= eff_total);

        pos_next   = pos_reg;
        total_next = total_reg;
        if (push)
        begin
            pos_next   = last ? 16'd0 : pos_inc;
            total_next = eff_total;
        end

        push_cmd.payload      = payload_byte;
        push_cmd.first        = first;
        push_cmd.last         = last;
        push_cmd.frame_number = frame_number;
        push_cmd.event_code   = event_mapped;
        push_cmd.length_field = len_sat + crcf_pkg::HDR_EXTRA;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 16'd0;
            total_reg <= 16'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

endmodule

### hdl/crcf_queue.sv
// short command queue between the classifier and the byte sequencer
// depends on crcf_pkg
`timescale 1ns / 1ps

module crcf_queue #(
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  crcf_pkg::crcf_cmd_t      push_cmd,
    input  logic                     pop,
    output crcf_pkg::crcf_cmd_t      head,
    output crcf_pkg::crcf_q_status_t status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    crcf_pkg::crcf_cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/crcf_back.sv
// output side: expands queued commands into header, payload and crc bytes
// depends on crcf_pkg
`timescale 1ns / 1ps

module crcf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crcf_pkg::crcf_cmd_t         head,
    input  crcf_pkg::crcf_q_status_t    q_status,
    input  logic [7:0]                  version,
    output crcf_pkg::crcf_back_status_t status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast
);

    crcf_pkg::crcf_phase_t phase_reg, phase_next, cur_phase;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  out_data_reg, out_data_next, byte_c;
    logic        out_last_reg, out_last_next;
    logic        out_valid_reg, out_valid_next;
    logic        advance, pop;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.phase = cur_phase;
    assign status.pop   = pop;

    always_comb
    begin
        if (phase_reg == crcf_pkg::PH_NEW)
            cur_phase = head.first ? crcf_pkg::PH_SOF : crcf_pkg::PH_PAYLOAD;
        else
            cur_phase = phase_reg;

        // output register frees up when empty or being taken this cycle
        advance = !q_status.empty && (!out_valid_reg || m_tready);
        pop     = advance && (cur_phase == crcf_pkg::PH_CRC_HI
                  || (cur_phase == crcf_pkg::PH_PAYLOAD && !head.last));

        unique case (cur_phase)
            crcf_pkg::PH_SOF:     byte_c = crcf_pkg::START_BYTE;
            crcf_pkg::PH_LEN_HI:  byte_c = head.length_field[15:8];
            crcf_pkg::PH_LEN_LO:  byte_c = head.length_field[7:0];
            crcf_pkg::PH_FNUM:    byte_c = head.frame_number;
            crcf_pkg::PH_EVENT:   byte_c = head.event_code;
            crcf_pkg::PH_VER:     byte_c = version;
            crcf_pkg::PH_PAYLOAD: byte_c = head.payload;
            crcf_pkg::PH_CRC_LO:  byte_c = crc_reg[7:0];
            crcf_pkg::PH_CRC_HI:  byte_c = crc_reg[15:8];
            default:              byte_c = head.payload;
        endcase

        phase_next     = phase_reg;
        crc_next       = crc_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        if (advance)
        begin
            out_data_next  = byte_c;
            out_last_next  = (cur_phase == crcf_pkg::PH_CRC_HI);
            out_valid_next = 1'b1;

            unique case (cur_phase)
                crcf_pkg::PH_SOF:     phase_next = crcf_pkg::PH_LEN_HI;
                crcf_pkg::PH_LEN_HI:  phase_next = crcf_pkg::PH_LEN_LO;
                crcf_pkg::PH_LEN_LO:  phase_next = crcf_pkg::PH_FNUM;
                crcf_pkg::PH_FNUM:    phase_next = crcf_pkg::PH_EVENT;
                crcf_pkg::PH_EVENT:   phase_next = crcf_pkg::PH_VER;
                crcf_pkg::PH_VER:     phase_next = crcf_pkg::PH_PAYLOAD;
                crcf_pkg::PH_PAYLOAD: phase_next = head.last ? crcf_pkg::PH_CRC_LO
                                                             : crcf_pkg::PH_NEW;
                crcf_pkg::PH_CRC_LO:  phase_next = crcf_pkg::PH_CRC_HI;
                crcf_pkg::PH_CRC_HI:  phase_next = crcf_pkg::PH_NEW;
                default:              phase_next = crcf_pkg::PH_NEW;
            endcase

            case (cur_phase)
                crcf_pkg::PH_SOF:
                    crc_next = crcf_pkg::CRC_INIT;
                crcf_pkg::PH_FNUM, crcf_pkg::PH_EVENT, crcf_pkg::PH_VER,
                crcf_pkg::PH_PAYLOAD:
                    crc_next = crcf_pkg::crc_byte(crc_reg, byte_c);
                crcf_pkg::PH_CRC_HI:
                    crc_next = crcf_pkg::CRC_INIT;
                default:
                    crc_next = crc_reg;
            endcase
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= crcf_pkg::PH_NEW;
            crc_reg       <= crcf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

### hdl/crc16_modbus_frame_builder.sv
// channel   dir  payload                                            handshake
// s_axis    in   tdata: payload_byte, payload_length, frame_number,  tvalid/tready
//                event_code
// m_axis    out  tdata: out_byte; tlast: frame_end                  tvalid/tready
// cfg       in   cfg_wdata: protocol_version                        cfg_we
//
// one output byte per cycle while the sink is ready and the queue is not empty;
// a mid-frame input byte yields only its payload byte, a first byte also the header
// before it, a last byte also the crc after it; the byte sequencer in crcf_back sets
// that rate; the command queue lets input transfers continue through a header or crc tail
// asynchronous active-low reset; version resets to 1, the crc to 0xFFFF
// top level: holds the version register and joins front, queue and back
// depends on crcf_pkg, crcf_front, crcf_queue, crcf_back, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc16_modbus_frame_builder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // payload_byte, payload_length, frame_number, event_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0] version_reg, version_next;

    logic                        push;
    crcf_pkg::crcf_cmd_t         push_cmd;
    crcf_pkg::crcf_cmd_t         head;
    crcf_pkg::crcf_q_status_t    q_status;
    crcf_pkg::crcf_back_status_t b_status;

    assign version_next = cfg_we ? cfg_wdata : version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            version_reg <= crcf_pkg::VERSION_RST;
        else
            version_reg <= version_next;
    end

    crcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    crcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (b_status.pop),
        .head     (head),
        .status   (q_status)
    );

    crcf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .version  (version_reg),
        .status   (b_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // back end never drains an empty queue
    `CRCF_ASSERT_IMP(a_pop_nonempty, b_status.pop, !q_status.empty)
    // crc tail only follows a byte classified as last of its frame
    `CRCF_ASSERT_IMP(a_crc_on_last,
        !q_status.empty && (b_status.phase == crcf_pkg::PH_CRC_LO
        || b_status.phase == crcf_pkg::PH_CRC_HI), head.last)
    // an input transfer always leaves work queued
    `CRCF_ASSERT_NXT(a_push_queued, push, !q_status.empty)

endmodule
